// ===== rtl/snqh_pkg.sv =====
// Shared types, constants, decimal tables and the microcode program of the
// sensor noise/quantize/hold block. No dependencies.
`timescale 1ns / 1ps

package snqh_pkg;

  localparam int FRAC_BITS     = 16;  // fraction bits of the value format
  localparam int REL_FRAC_BITS = 16;  // fraction bits of the relative error
  localparam int MAX_DIGITS    = 4;   // most decimal fraction digits kept
  localparam int DIV_N         = 30;  // dividend width of the reciprocal divide
  localparam int STEP_W        = 5;
  localparam int NUM_STEPS     = 17;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_VALUE       = 3'd0,
    REG_MAX_VALUE       = 3'd1,
    REG_DECIMAL_DIGITS  = 3'd2,
    REG_UPDATE_INTERVAL = 3'd3,
    REG_ABSOLUTE_ERROR  = 3'd4,
    REG_RELATIVE_ERROR  = 3'd5,
    REG_SUM_ERRORS      = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [2:0]         decimal_digits;
    logic [31:0]        update_interval;
    logic [30:0]        absolute_error;
    logic [23:0]        relative_error;
    logic               sum_errors;
  } cfg_t;

  // Datapath operations, one per microcode step.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_REL_MUL,
    OP_ERR,
    OP_OFF_LL,
    OP_OFF_HL,
    OP_OFF_LH,
    OP_OFF_HH,
    OP_OFF_SUM,
    OP_MEAS,
    OP_CLAMP,
    OP_KCALC,
    OP_QA_MUL,
    OP_QA,
    OP_REM_MUL,
    OP_REM,
    OP_QC_MUL,
    OP_STORE,
    OP_EMIT
  } uop_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_HOLD,
    COND_NOERR,
    COND_CLAMP
  } cond_t;

  typedef struct packed {
    uop_t              op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  localparam logic [STEP_W-1:0] STEP_FIRST = 5'd0;
  localparam logic [STEP_W-1:0] STEP_CLAMP = 5'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 5'd16;

  // The program. Steps run in order unless the condition jumps to target.
  localparam uword_t UCODE [NUM_STEPS] = '{
    '{OP_REL_MUL, COND_HOLD,  STEP_EMIT},
    '{OP_ERR,     COND_NOERR, STEP_CLAMP},
    '{OP_OFF_LL,  COND_NEVER, STEP_FIRST},
    '{OP_OFF_HL,  COND_NEVER, STEP_FIRST},
    '{OP_OFF_LH,  COND_NEVER, STEP_FIRST},
    '{OP_OFF_HH,  COND_NEVER, STEP_FIRST},
    '{OP_OFF_SUM, COND_NEVER, STEP_FIRST},
    '{OP_MEAS,    COND_NEVER, STEP_FIRST},
    '{OP_CLAMP,   COND_CLAMP, STEP_EMIT},
    '{OP_KCALC,   COND_NEVER, STEP_FIRST},
    '{OP_QA_MUL,  COND_NEVER, STEP_FIRST},
    '{OP_QA,      COND_NEVER, STEP_FIRST},
    '{OP_REM_MUL, COND_NEVER, STEP_FIRST},
    '{OP_REM,     COND_NEVER, STEP_FIRST},
    '{OP_QC_MUL,  COND_NEVER, STEP_FIRST},
    '{OP_STORE,   COND_NEVER, STEP_FIRST},
    '{OP_EMIT,    COND_NEVER, STEP_FIRST}
  };

  typedef struct packed {
    logic load;
    uop_t op;
  } dp_ctrl_t;

  typedef struct packed {
    logic hold;
    logic noerr;
    logic clamp;
  } dp_flags_t;

  typedef struct packed {
    logic signed [31:0] reading;
    logic signed [31:0] held_reading;
    logic [31:0]        sample_time;
    logic               sample_time_valid;
  } result_t;

  // 10^d for the kept decimal digits.
  function automatic logic [13:0] dec_factor(input logic [2:0] d);
    logic [13:0] f;
    case (d)
      3'd0:    f = 14'd1;
      3'd1:    f = 14'd10;
      3'd2:    f = 14'd100;
      3'd3:    f = 14'd1000;
      default: f = 14'd10000;
    endcase
    return f;
  endfunction

  // ceil(2^(DIV_N + l) / 10^d), exact quotient for dividends below 2^DIV_N.
  function automatic logic [30:0] dec_recip(input logic [2:0] d);
    logic [30:0] m;
    case (d)
      3'd0:    m = 31'd1073741824;
      3'd1:    m = 31'd1717986919;
      3'd2:    m = 31'd1374389535;
      3'd3:    m = 31'd1099511628;
      default: m = 31'd1759218605;
    endcase
    return m;
  endfunction

  // l = ceil(log2(10^d)).
  function automatic logic [3:0] dec_lshift(input logic [2:0] d);
    logic [3:0] l;
    case (d)
      3'd0:    l = 4'd0;
      3'd1:    l = 4'd4;
      3'd2:    l = 4'd7;
      3'd3:    l = 4'd10;
      default: l = 4'd14;
    endcase
    return l;
  endfunction

endpackage

// ===== rtl/snqh_if.sv =====
// Valid/ready channel interfaces for the input samples and the readings.
// Depends on nothing.
`timescale 1ns / 1ps

interface snqh_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic [31:0]        current_time;
  logic [31:0]        random_word;

  modport source (output valid, sample_value, current_time, random_word, input ready);
  modport sink   (input valid, sample_value, current_time, random_word, output ready);
endinterface

interface snqh_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] reading;
  logic signed [31:0] held_reading;
  logic [31:0]        sample_time;
  logic               sample_time_valid;

  modport source (output valid, reading, held_reading, sample_time, sample_time_valid,
                  input ready);
  modport sink   (input valid, reading, held_reading, sample_time, sample_time_valid,
                  output ready);
endinterface

// ===== rtl/snqh_dp.sv =====
// Datapath of the sensor block: operand registers, one shared registered
// 32x32 multiplier and the hold state. Depends on snqh_pkg.
`timescale 1ns / 1ps

module snqh_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  snqh_pkg::dp_ctrl_t  ctrl,
  input  snqh_pkg::cfg_t      cfg,
  input  logic signed [31:0]  ld_value,
  input  logic [31:0]         ld_time,
  input  logic [31:0]         ld_random,
  output snqh_pkg::dp_flags_t flags,
  output snqh_pkg::result_t   result
);

  logic signed [31:0] v_r;
  logic [31:0]        now_r;
  logic [31:0]        u_r;
  logic [63:0]        prod_r;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic signed [41:0] err_r, err_nxt;
  logic [57:0]        acc_r, acc_nxt;
  logic signed [43:0] m_r, m_nxt;
  logic [29:0]        kmag_r, kmag_nxt;
  logic [29:0]        a_r, a_nxt;
  logic [29:0]        y_r, y_nxt;
  logic signed [31:0] rd_r, rd_nxt;
  logic signed [31:0] held_value_r, held_value_nxt;
  logic [31:0]        held_time_r, held_time_nxt;
  logic               have_r, have_nxt;

  logic [2:0]         digits;
  logic [13:0]        factor;
  logic [30:0]        recip;
  logic [5:0]         dshift;
  logic [31:0]        vmag;
  logic [40:0]        w;
  logic               hold_hit;
  logic [56:0]        rel_rnd;
  logic [39:0]        rel_mag;
  logic signed [41:0] rel_s;
  logic signed [41:0] abs_s;
  logic signed [41:0] err_calc;
  logic signed [43:0] m_neg;
  logic [31:0]        mmag;
  logic signed [43:0] lim_lo;
  logic signed [43:0] lim_hi;
  logic               below;
  logic               above;
  logic [46:0]        k_rnd;
  logic [13:0]        rem_b;
  logic [16:0]        qc;
  logic [33:0]        q;
  logic [33:0]        q_neg;
  logic signed [31:0] r_sat;

  assign digits = (cfg.decimal_digits > 3'(snqh_pkg::MAX_DIGITS)) ?
                  3'(snqh_pkg::MAX_DIGITS) : cfg.decimal_digits;
  assign factor = snqh_pkg::dec_factor(digits);
  assign recip  = snqh_pkg::dec_recip(digits);
  assign dshift = 6'(snqh_pkg::DIV_N) + {2'b00, snqh_pkg::dec_lshift(digits)};

  assign vmag = v_r[31] ? 32'(-v_r) : 32'(v_r);
  assign w    = {err_r[39:0], 1'b0};

  assign hold_hit = have_r &&
                    ({1'b0, now_r} < ({1'b0, held_time_r} + {1'b0, cfg.update_interval}));

  // Relative bound, rounded half away from zero, signed like the value.
  assign rel_rnd = {1'b0, prod_r[55:0]} + (57'd1 << (snqh_pkg::REL_FRAC_BITS - 1));
  assign rel_mag = rel_rnd[snqh_pkg::REL_FRAC_BITS +: 40];
  assign rel_s   = v_r[31] ? -$signed({2'b00, rel_mag}) : $signed({2'b00, rel_mag});
  assign abs_s   = $signed({11'd0, cfg.absolute_error});
  assign err_calc = cfg.sum_errors ? (abs_s + rel_s) : ((abs_s > rel_s) ? abs_s : rel_s);

  assign m_neg = -m_r;
  assign mmag  = m_r[43] ? m_neg[31:0] : m_r[31:0];
  assign lim_lo = 44'(cfg.min_value);
  assign lim_hi = 44'(cfg.max_value);
  assign below  = m_r < lim_lo;
  assign above  = m_r > lim_hi;

  assign k_rnd = {1'b0, prod_r[45:0]} + (47'd1 << (snqh_pkg::FRAC_BITS - 1));
  assign rem_b = 14'(kmag_r - prod_r[29:0]);
  assign qc    = 17'(prod_r >> dshift);
  assign q     = 34'({a_r[17:0], {snqh_pkg::FRAC_BITS{1'b0}}}) + 34'(qc);
  assign q_neg = -q;

  always_comb begin
    if (m_r[43]) begin
      r_sat = (q > 34'h080000000) ? 32'sh80000000 : $signed(q_neg[31:0]);
    end else begin
      r_sat = (q > 34'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(q[31:0]);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      snqh_pkg::OP_REL_MUL: begin
        mul_a = vmag;
        mul_b = {8'd0, cfg.relative_error};
      end
      snqh_pkg::OP_OFF_LL: begin
        mul_a = w[31:0];
        mul_b = {16'd0, u_r[15:0]};
      end
      snqh_pkg::OP_OFF_HL: begin
        mul_a = {23'd0, w[40:32]};
        mul_b = {16'd0, u_r[15:0]};
      end
      snqh_pkg::OP_OFF_LH: begin
        mul_a = w[31:0];
        mul_b = {16'd0, u_r[31:16]};
      end
      snqh_pkg::OP_OFF_HH: begin
        mul_a = {23'd0, w[40:32]};
        mul_b = {16'd0, u_r[31:16]};
      end
      snqh_pkg::OP_CLAMP: begin
        mul_a = mmag;
        mul_b = {18'd0, factor};
      end
      snqh_pkg::OP_QA_MUL: begin
        mul_a = {2'b00, kmag_r};
        mul_b = {1'b0, recip};
      end
      snqh_pkg::OP_REM_MUL: begin
        mul_a = {2'b00, a_r};
        mul_b = {18'd0, factor};
      end
      snqh_pkg::OP_QC_MUL: begin
        mul_a = {2'b00, y_r};
        mul_b = {1'b0, recip};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    err_nxt        = err_r;
    acc_nxt        = acc_r;
    m_nxt          = m_r;
    kmag_nxt       = kmag_r;
    a_nxt          = a_r;
    y_nxt          = y_r;
    rd_nxt         = rd_r;
    held_value_nxt = held_value_r;
    held_time_nxt  = held_time_r;
    have_nxt       = have_r;
    case (ctrl.op)
      snqh_pkg::OP_REL_MUL: begin
        if (hold_hit) begin
          rd_nxt = held_value_r;
        end
      end
      snqh_pkg::OP_ERR: begin
        err_nxt = err_calc;
        m_nxt   = 44'(v_r);
      end
      snqh_pkg::OP_OFF_HL: acc_nxt = {10'd0, prod_r[47:0]};
      snqh_pkg::OP_OFF_LH: acc_nxt = acc_r + {1'b0, prod_r[24:0], 32'd0};
      snqh_pkg::OP_OFF_HH: acc_nxt = (acc_r >> 16) + {10'd0, prod_r[47:0]};
      snqh_pkg::OP_OFF_SUM: acc_nxt = acc_r + {1'b0, prod_r[24:0], 32'd0};
      snqh_pkg::OP_MEAS: begin
        m_nxt = 44'(v_r) - 44'(err_r) + $signed({2'b00, acc_r[57:16]});
      end
      snqh_pkg::OP_CLAMP: begin
        rd_nxt = below ? cfg.min_value : cfg.max_value;
      end
      snqh_pkg::OP_KCALC: kmag_nxt = k_rnd[snqh_pkg::FRAC_BITS +: 30];
      snqh_pkg::OP_QA: a_nxt = 30'(prod_r >> dshift);
      snqh_pkg::OP_REM: begin
        y_nxt = 30'({rem_b, {snqh_pkg::FRAC_BITS{1'b0}}}) + 30'(factor >> 1);
      end
      snqh_pkg::OP_STORE: begin
        rd_nxt         = r_sat;
        held_value_nxt = r_sat;
        held_time_nxt  = now_r;
        have_nxt       = 1'b1;
      end
      default: begin
        rd_nxt = rd_r;
      end
    endcase
  end

  assign flags.hold  = (ctrl.op == snqh_pkg::OP_REL_MUL) && hold_hit;
  assign flags.noerr = (ctrl.op == snqh_pkg::OP_ERR) && (err_calc <= 42'sd0);
  assign flags.clamp = (ctrl.op == snqh_pkg::OP_CLAMP) && (below || above);

  assign result.reading           = rd_r;
  assign result.held_reading      = held_value_r;
  assign result.sample_time       = held_time_r;
  assign result.sample_time_valid = have_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      v_r   <= ld_value;
      now_r <= ld_time;
      u_r   <= ld_random;
    end
    prod_r <= 64'(mul_a) * 64'(mul_b);
    err_r  <= err_nxt;
    acc_r  <= acc_nxt;
    m_r    <= m_nxt;
    kmag_r <= kmag_nxt;
    a_r    <= a_nxt;
    y_r    <= y_nxt;
    rd_r   <= rd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_value_r <= '0;
      held_time_r  <= '0;
      have_r       <= 1'b0;
    end else begin
      held_value_r <= held_value_nxt;
      held_time_r  <= held_time_nxt;
      have_r       <= have_nxt;
    end
  end

  // The held sample only moves on a store step.
  a_held_only_on_store: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(held_time_r) |-> $past(ctrl.op == snqh_pkg::OP_STORE))
    else $error("held time changed outside a store step");

  // A value that reaches quantization has passed the limits, so fits 32 bits.
  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == snqh_pkg::OP_STORE) |-> (m_r[43:31] == '0 || m_r[43:31] == '1))
    else $error("measurement outside 32-bit range at store");

endmodule

// ===== rtl/sensor_noise_quantize_hold.sv =====
// Top level of the sensor noise/quantize/hold block: configuration registers,
// microcode sequencer and output register. Depends on snqh_pkg, snqh_if, snqh_dp.
`timescale 1ns / 1ps

// Usage
// Each input transaction on in_ch carries a true value (signed Q16.16), the
// present tick and 32 random bits. Each one yields exactly one output
// transaction on out_ch: the reading (the limit itself when the noisy value is
// clamped), the held reading, its sample tick and a flag set once a sample has
// been stored. Registers are written through cfg_we/cfg_index/cfg_data at an
// edge with cfg_we high; the user must write them only while no transaction
// is in flight, which the block itself does not enforce. Indexes beyond the
// list are ignored. A microcode program of 17 steps drives one shared,
// registered 32x32 multiplier, which computes nine products in turn. The
// program jumps to its last step when the held value is returned and to the
// clamp step when the error bound is not positive; a clamped reading then goes
// to the last step, any other on through rounding. The next input transaction
// is accepted the cycle after the result is loaded into the output register.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// held sample and empties the output register. While the receiver stalls, the
// output register holds its transaction and the program waits at its last
// step; an input transaction is still taken once that step has passed.
module sensor_noise_quantize_hold (
  input  logic                                clk,
  input  logic                                rst_n,
  snqh_in_if.sink                             in_ch,
  snqh_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [snqh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [snqh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  snqh_pkg::cfg_t                   cfg_r;
  logic                             busy_r;
  logic [snqh_pkg::STEP_W-1:0]      step_r;
  logic                             out_valid_r;
  snqh_pkg::result_t                out_res_r;

  snqh_pkg::uword_t                 uword;
  snqh_pkg::dp_ctrl_t               ctrl;
  snqh_pkg::dp_flags_t              flags;
  snqh_pkg::result_t                dp_res;
  logic                             in_fire;
  logic                             emit_fire;
  logic                             jump;

  // Configuration registers. A write to an unused index does nothing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_value       <= 32'sh80000000;
      cfg_r.max_value       <= 32'sh7FFFFFFF;
      cfg_r.decimal_digits  <= 3'(snqh_pkg::MAX_DIGITS);
      cfg_r.update_interval <= '0;
      cfg_r.absolute_error  <= '0;
      cfg_r.relative_error  <= '0;
      cfg_r.sum_errors      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        snqh_pkg::REG_MIN_VALUE:       cfg_r.min_value       <= $signed(cfg_data);
        snqh_pkg::REG_MAX_VALUE:       cfg_r.max_value       <= $signed(cfg_data);
        snqh_pkg::REG_DECIMAL_DIGITS:  cfg_r.decimal_digits  <= cfg_data[2:0];
        snqh_pkg::REG_UPDATE_INTERVAL: cfg_r.update_interval <= cfg_data;
        snqh_pkg::REG_ABSOLUTE_ERROR:  cfg_r.absolute_error  <= cfg_data[30:0];
        snqh_pkg::REG_RELATIVE_ERROR:  cfg_r.relative_error  <= cfg_data[23:0];
        snqh_pkg::REG_SUM_ERRORS:      cfg_r.sum_errors      <= cfg_data[0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // The step counter addresses the program; the control word names the
  // datapath operation and an optional conditional jump.
  assign uword     = snqh_pkg::UCODE[step_r];
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign emit_fire = busy_r && (uword.op == snqh_pkg::OP_EMIT) &&
                     (!out_valid_r || out_ch.ready);

  always_comb begin
    case (uword.cond)
      snqh_pkg::COND_HOLD:  jump = flags.hold;
      snqh_pkg::COND_NOERR: jump = flags.noerr;
      snqh_pkg::COND_CLAMP: jump = flags.clamp;
      default:              jump = 1'b0;
    endcase
  end

  assign ctrl.load = in_fire;
  assign ctrl.op   = busy_r ? uword.op : snqh_pkg::OP_NOP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= snqh_pkg::STEP_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
        step_r <= snqh_pkg::STEP_FIRST;
      end else if (busy_r) begin
        if (uword.op == snqh_pkg::OP_EMIT) begin
          if (emit_fire) begin
            busy_r <= 1'b0;
          end
        end else begin
          step_r <= jump ? uword.target : step_r + snqh_pkg::STEP_W'(1);
        end
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload is captured as the program finishes.
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_res_r <= dp_res;
    end
  end

  snqh_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .cfg       (cfg_r),
    .ld_value  (in_ch.sample_value),
    .ld_time   (in_ch.current_time),
    .ld_random (in_ch.random_word),
    .flags     (flags),
    .result    (dp_res)
  );

  assign in_ch.ready              = !busy_r;
  assign out_ch.valid             = out_valid_r;
  assign out_ch.reading           = out_res_r.reading;
  assign out_ch.held_reading      = out_res_r.held_reading;
  assign out_ch.sample_time       = out_res_r.sample_time;
  assign out_ch.sample_time_valid = out_res_r.sample_time_valid;

  // A new transaction always starts the program at its first step.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (busy_r && step_r == snqh_pkg::STEP_FIRST))
    else $error("program did not start at the first step");

  // The step counter never runs past the final step.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= snqh_pkg::STEP_EMIT))
    else $error("step counter beyond the program");

  // A clamped reading goes straight to the result.
  a_clamp_jump: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && flags.clamp) |=> (step_r == snqh_pkg::STEP_EMIT))
    else $error("clamp did not jump to the result step");

  // Finishing a transaction fills the output register and frees the input.
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (out_valid_r && !busy_r))
    else $error("result not presented after the last step");

endmodule
